/* rtl/core/pds_pkg.sv */
// Shared constants and types for the projectile drag stepper.
// Holds fixed-point constants, the CORDIC arctangent table and register indexes.
// No dependencies.
`default_nettype none

package pds_pkg;

  // Configuration port
  localparam int unsigned CfgDataW = 24;

  typedef enum logic [1:0] {
    REG_AIR_DENSITY  = 2'd0,
    REG_PROJ_MASS    = 2'd1,
    REG_WIND_SPEED   = 2'd2,
    REG_TARGET_RANGE = 2'd3
  } cfg_reg_e;

  // Input item kinds
  localparam logic OP_LAUNCH = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // Physics constants
  localparam logic [19:0] G_Q16     = 20'd642908;    // 9.81 m/s^2, Q16.16
  localparam logic [12:0] DT_Q16    = 13'd6554;      // 0.1 s, Q16.16
  localparam logic [24:0] DRAG_C    = 25'd31708639;  // 0.5*Cd*area, Q0.32
  localparam logic [16:0] ONE_M     = 17'd65536;     // 1 m, Q16.16

  // Angle handling: degrees in Q16.16, hundredths scaled by 2^38/100
  localparam logic [31:0] ANG_RECIP = 32'd2748779070;
  localparam logic signed [25:0] DEG90  = 26'sd5898240;
  localparam logic signed [25:0] DEG180 = 26'sd11796480;
  localparam logic signed [25:0] DEG270 = 26'sd17694720;
  localparam logic signed [25:0] DEG360 = 26'sd23592960;

  // CORDIC start vector, gain compensated, Q2.30
  localparam logic signed [33:0] CORDIC_K = 34'sd652032874;

  // atan(2^-i) in Q16.16 degrees
  function automatic logic [21:0] atan_deg(input logic [3:0] i);
    logic [21:0] r;
    case (i)
      4'd0:    r = 22'd2949120;
      4'd1:    r = 22'd1740967;
      4'd2:    r = 22'd919879;
      4'd3:    r = 22'd466945;
      4'd4:    r = 22'd234379;
      4'd5:    r = 22'd117304;
      4'd6:    r = 22'd58666;
      4'd7:    r = 22'd29335;
      4'd8:    r = 22'd14668;
      4'd9:    r = 22'd7334;
      4'd10:   r = 22'd3667;
      4'd11:   r = 22'd1833;
      4'd12:   r = 22'd917;
      4'd13:   r = 22'd458;
      4'd14:   r = 22'd229;
      default: r = 22'd115;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/projectile_drag_stepper.sv */
// Projectile drag stepper top level: sequencer, CORDIC, divider and shared multiplier.
// Depends on pds_pkg.
`default_nettype none

// Two-dimensional projectile stepper with quadratic drag in Q16.16. A launch item
// (tuser = 0) sets velocity from speed and elevation plus wind, clears position and
// time, and derives drag per mass, through 16 CORDIC rotations, two passes of the
// multiplier and a restoring divide by the mass. A tick item (tuser = 1) does one
// 0.1 s Euler step through eight products on a single multiplier that takes 16 bits
// of its second operand per cycle. A tick after landing returns at once. One item is
// in work at a time; the result sits in an output register, so the next item is
// taken while it waits.
module projectile_drag_stepper #(
  parameter int unsigned VALUE_WIDTH      = 32,
  parameter int unsigned STEP_COUNT_WIDTH = 16
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  // Configuration writes
  input  wire                     cfg_valid_i,
  output logic                    cfg_ready_o,
  input  pds_pkg::cfg_reg_e       cfg_index_i,
  input  wire [pds_pkg::CfgDataW-1:0] cfg_data_i,
  // Input stream
  input  wire                     s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire [31:0]              s_axis_tdata,  // initial_speed[15:0], launch_angle[30:16]
  input  wire                     s_axis_tuser,  // op
  // Result stream
  output logic                    m_axis_tvalid,
  input  wire                     m_axis_tready,
  output logic [87:0]             m_axis_tdata   // elapsed_steps[15:0], range_x[47:16],
                                                 // height_y[79:48], landed[80], on_target[81]
);
  import pds_pkg::*;

  localparam int unsigned W    = VALUE_WIDTH;
  localparam int unsigned SCW  = STEP_COUNT_WIDTH;
  localparam int unsigned MW   = (W > 32) ? W : 32;
  localparam int unsigned NCH  = (MW + 15) / 16;
  localparam int unsigned BW   = NCH * 16;
  localparam int unsigned AW   = MW + BW;
  localparam int unsigned SW   = MW + 2;
  localparam int unsigned DW   = ((W > 33) ? W : 33) + 2;
  localparam int unsigned CEW  = (SCW > 16) ? SCW : 16;
  localparam int unsigned MCW  = $clog2(NCH + 1);

  localparam logic [W-1:0] VMAX  = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] NEG_G = W'(0) - W'(G_Q16);

  // Sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RED    = 3'd1;
  localparam logic [2:0] S_CORD   = 3'd2;
  localparam logic [2:0] S_MSTART = 3'd3;
  localparam logic [2:0] S_MRUN   = 3'd4;
  localparam logic [2:0] S_DIV    = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  // Product scaling codes
  localparam logic [1:0] SH16 = 2'd0;
  localparam logic [1:0] SH22 = 2'd1;
  localparam logic [1:0] SH32 = 2'd2;

  // Saturating add and subtract at W bits
  function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
                                                  input logic signed [W-1:0] b);
    logic signed [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) return s[W] ? ~VMAX : VMAX;
    return s[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] sat_sub(input logic signed [W-1:0] a,
                                                  input logic signed [W-1:0] b);
    logic signed [W:0] s;
    s = {a[W-1], a} - {b[W-1], b};
    if (s[W] != s[W-1]) return s[W] ? ~VMAX : VMAX;
    return s[W-1:0];
  endfunction

  function automatic logic [SW-1:0] absv(input logic signed [SW-1:0] v);
    return v[SW-1] ? SW'(-v) : SW'(v);
  endfunction

  // Configuration registers
  logic [17:0]        rho_q;
  logic [15:0]        mass_q;
  logic signed [14:0] wind_q;
  logic [23:0]        target_q;

  // Item state
  logic [2:0]            state_q, state_d;
  logic                  launch_q;
  logic [2:0]            ph_q;
  logic [15:0]           speed_q;
  logic signed [25:0]    z_q;
  logic                  flip_q;
  logic [3:0]            ci_q;
  logic signed [33:0]    cx_q, cy_q;
  logic [26:0]           dpm_q;
  logic [15:0]           rem_q;
  logic [4:0]            dcnt_q;
  logic signed [W-1:0]   vx_q, vy_q, px_q, py_q, t_q;
  logic [SCW-1:0]        cnt_q;
  logic                  landed_q;

  // Multiplier registers
  logic [MW-1:0]   ma_q;
  logic [BW-1:0]   mb_q;
  logic            mneg_q;
  logic [1:0]      msh_q;
  logic [AW-1:0]   macc_q;
  logic [MCW-1:0]  mcnt_q;

  logic s_xfer, m_xfer;
  assign s_xfer = s_axis_tvalid && s_axis_tready;
  assign m_xfer = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rho_q    <= 18'd80282;
      mass_q   <= 16'd100;
      wind_q   <= 15'sd2560;
      target_q <= 24'd256000;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_AIR_DENSITY:  rho_q    <= cfg_data_i[17:0];
        REG_PROJ_MASS:    mass_q   <= cfg_data_i[15:0];
        REG_WIND_SPEED:   wind_q   <= cfg_data_i[14:0];
        REG_TARGET_RANGE: target_q <= cfg_data_i[23:0];
        default:          ;
      endcase
    end
  end

  // Launch front end: degrees and drag numerator
  logic [46:0] ang_prod;
  logic [42:0] drag_num;
  assign ang_prod = s_axis_tdata[30:16] * ANG_RECIP;
  assign drag_num = rho_q * DRAG_C;

  // CORDIC rotation step
  logic signed [33:0] cdx, cdy, ncx, ncy;
  logic signed [25:0] catn, nz;
  always_comb begin
    cdx  = cy_q >>> ci_q;
    cdy  = cx_q >>> ci_q;
    catn = 26'(atan_deg(ci_q));
    if (!z_q[25]) begin
      ncx = cx_q - cdx;
      ncy = cy_q + cdy;
      nz  = z_q - catn;
    end else begin
      ncx = cx_q + cdx;
      ncy = cy_q - cdy;
      nz  = z_q + catn;
    end
  end

  // Divider step by the mass (zero counts as one)
  logic [15:0] mass_eff;
  logic [16:0] dtrial;
  logic        dge;
  assign mass_eff = (mass_q == 16'd0) ? 16'd1 : mass_q;
  assign dtrial   = {rem_q, dpm_q[26]};
  assign dge      = (dtrial >= {1'b0, mass_eff});

  // Operand selection for the next product
  logic signed [SW-1:0] op_a, op_b;
  logic                 op_babs;
  logic [1:0]           op_sh;
  always_comb begin
    op_a    = SW'(vx_q);
    op_b    = SW'(DT_Q16);
    op_babs = 1'b0;
    op_sh   = SH16;
    if (launch_q) begin
      op_a  = SW'(speed_q);
      op_b  = (ph_q == 3'd0) ? SW'(cx_q) : SW'(cy_q);
      op_sh = SH22;
    end else begin
      case (ph_q)
        3'd0: begin op_a = SW'(vx_q); op_b = SW'(vx_q); op_babs = 1'b1; end
        3'd1: begin op_a = SW'(t_q); op_b = SW'(dpm_q); op_sh = SH32; end
        3'd2: op_a = SW'(t_q);
        3'd3: begin op_a = SW'(vy_q); op_b = SW'(vy_q); op_babs = 1'b1; end
        3'd4: begin op_a = SW'(t_q); op_b = SW'(dpm_q); op_sh = SH32; end
        3'd5: op_a = SW'(t_q);
        3'd6: op_a = SW'(vx_q);
        default: op_a = SW'(vy_q);
      endcase
    end
  end

  logic [SW-1:0] op_amag, op_bmag;
  assign op_amag = absv(op_a);
  assign op_bmag = absv(op_b);

  // Multiplier: one 16-bit digit of the second operand per cycle, then scale and clamp
  logic [MW+15:0] m_pp;
  logic [AW-1:0]  m_shr, m_lim, m_mag;
  logic signed [W-1:0] m_res;
  assign m_pp = ma_q * mb_q[BW-1 -: 16];
  always_comb begin
    case (msh_q)
      SH16:    m_shr = macc_q >> 16;
      SH22:    m_shr = macc_q >> 22;
      default: m_shr = macc_q >> 32;
    endcase
    m_lim = AW'(VMAX) + AW'(mneg_q);
    m_mag = (m_shr > m_lim) ? m_lim : m_shr;
    m_res = mneg_q ? W'(-m_mag[W-1:0]) : m_mag[W-1:0];
  end

  logic signed [22:0] wind_s;
  logic signed [W-1:0] py_new;
  assign wind_s = {wind_q, 8'd0};
  assign py_new = sat_add(py_q, m_res);

  // Result fields
  logic signed [DW-1:0] xs, ys, dd, dabs;
  logic [CEW-1:0]       cext;
  logic [15:0]          o_steps;
  logic [31:0]          o_x, o_y;
  logic                 o_hit;
  always_comb begin
    xs   = DW'(px_q);
    ys   = DW'(py_q);
    dd   = xs - $signed(DW'({target_q, 8'd0}));
    dabs = dd[DW-1] ? -dd : dd;
    cext = CEW'(cnt_q);
    o_steps = (cext > CEW'(16'hFFFF)) ? 16'hFFFF : cext[15:0];
    if (xs > $signed(DW'(32'h7FFFFFFF)))       o_x = 32'h7FFFFFFF;
    else if (xs < -$signed(DW'(33'h80000000))) o_x = 32'h80000000;
    else                                       o_x = xs[31:0];
    if (ys > $signed(DW'(32'h7FFFFFFF)))       o_y = 32'h7FFFFFFF;
    else if (ys < -$signed(DW'(33'h80000000))) o_y = 32'h80000000;
    else                                       o_y = ys[31:0];
    o_hit = landed_q && (dabs <= $signed(DW'(ONE_M)));
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_xfer) begin
          if (s_axis_tuser == OP_LAUNCH) state_d = S_RED;
          else if (landed_q)             state_d = S_DONE;
          else                           state_d = S_MSTART;
        end
      end
      S_RED:    state_d = S_CORD;
      S_CORD:   if (ci_q == 4'd15) state_d = S_MSTART;
      S_MSTART: state_d = S_MRUN;
      S_MRUN: begin
        if (mcnt_q == MCW'(NCH)) begin
          if (launch_q && ph_q == 3'd1)       state_d = S_DIV;
          else if (!launch_q && ph_q == 3'd7) state_d = S_DONE;
          else                                state_d = S_MSTART;
        end
      end
      S_DIV:    if (dcnt_q == 5'd26) state_d = S_DONE;
      S_DONE:   if (!m_axis_tvalid || m_axis_tready) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      launch_q      <= 1'b0;
      ph_q          <= '0;
      ci_q          <= '0;
      dcnt_q        <= '0;
      mcnt_q        <= '0;
      m_axis_tvalid <= 1'b0;
      vx_q          <= '0;
      vy_q          <= '0;
      px_q          <= '0;
      py_q          <= '0;
      cnt_q         <= '0;
      dpm_q         <= '0;
      landed_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        S_IDLE: begin
          if (s_xfer) begin
            launch_q <= (s_axis_tuser == OP_LAUNCH);
            ph_q     <= '0;
            ci_q     <= '0;
            dcnt_q   <= '0;
            if (s_axis_tuser == OP_LAUNCH) begin
              dpm_q    <= drag_num[42:16];
              px_q     <= '0;
              py_q     <= '0;
              cnt_q    <= '0;
              landed_q <= 1'b0;
            end
          end
        end
        S_CORD: ci_q <= ci_q + 4'd1;
        S_MSTART: mcnt_q <= '0;
        S_MRUN: begin
          if (mcnt_q != MCW'(NCH)) begin
            mcnt_q <= mcnt_q + MCW'(1);
          end else begin
            ph_q <= ph_q + 3'd1;
            if (launch_q) begin
              if (ph_q == 3'd0) vx_q <= sat_add(m_res, W'(wind_s));
              else              vy_q <= m_res;
            end else begin
              case (ph_q)
                3'd2: vx_q <= sat_add(vx_q, m_res);
                3'd5: vy_q <= sat_add(vy_q, m_res);
                3'd6: px_q <= sat_add(px_q, m_res);
                3'd7: begin
                  py_q <= py_new;
                  if (cnt_q != {SCW{1'b1}}) cnt_q <= cnt_q + SCW'(1);
                  if (py_new[W-1]) landed_q <= 1'b1;
                end
                default: ;
              endcase
            end
          end
        end
        S_DIV: begin
          dcnt_q <= dcnt_q + 5'd1;
          dpm_q  <= {dpm_q[25:0], dge};
        end
        S_DONE: if (!m_axis_tvalid || m_axis_tready) m_axis_tvalid <= 1'b1;
        default: ;
      endcase
      if (m_xfer && state_q != S_DONE) m_axis_tvalid <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (s_xfer) begin
          speed_q <= s_axis_tdata[15:0];
          z_q     <= 26'(ang_prod[46:22]);
          cx_q    <= CORDIC_K;
          cy_q    <= '0;
          rem_q   <= '0;
        end
      end
      S_RED: begin
        flip_q <= 1'b0;
        if (z_q > DEG270) begin
          z_q <= z_q - DEG360;
        end else if (z_q > DEG90) begin
          z_q    <= z_q - DEG180;
          flip_q <= 1'b1;
        end
      end
      S_CORD: begin
        z_q <= nz;
        if (ci_q == 4'd15 && flip_q) begin
          cx_q <= -ncx;
          cy_q <= -ncy;
        end else begin
          cx_q <= ncx;
          cy_q <= ncy;
        end
      end
      S_MSTART: begin
        ma_q   <= op_amag[MW-1:0];
        mb_q   <= BW'(op_bmag[MW-1:0]);
        mneg_q <= op_a[SW-1] ^ (op_b[SW-1] && !op_babs);
        msh_q  <= op_sh;
        macc_q <= '0;
      end
      S_MRUN: begin
        if (mcnt_q != MCW'(NCH)) begin
          macc_q <= (macc_q << 16) + AW'(m_pp);
          mb_q   <= mb_q << 16;
        end else if (!launch_q) begin
          case (ph_q) inside
            3'd0, 3'd3: t_q <= m_res;
            3'd1:       t_q <= sat_sub(W'(0), m_res);
            3'd4:       t_q <= sat_sub(NEG_G, m_res);
            default:    ;
          endcase
        end
      end
      S_DIV: rem_q <= dge ? 16'(dtrial - {1'b0, mass_eff}) : dtrial[15:0];
      S_DONE: begin
        if (!m_axis_tvalid || m_axis_tready)
          m_axis_tdata <= {6'd0, o_hit, landed_q, o_y, o_x, o_steps};
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Testbench for projectile_drag_stepper: launches and time steps against a bit-exact
// flight predictor, under several idle and stall patterns and register settings.
// Depends on pds_pkg and the stepper RTL.
`timescale 1ns / 100ps

module tb_top;
  import pds_pkg::*;

  localparam longint VMAX  = 64'sd2147483647;
  localparam longint VMIN  = -VMAX - 1;
  localparam int     LIMIT = 900000;

  typedef struct packed {
    logic        on_target;
    logic        landed;
    logic [31:0] height_y;
    logic [31:0] range_x;
    logic [15:0] elapsed_steps;
  } flight_rpt_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  cfg_reg_e cfg_index_i = REG_AIR_DENSITY;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;

  projectile_drag_stepper i_dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor copy of registers and flight state
  longint rho_q, mass_q, wind_q, target_q;
  longint vx_q, vy_q, px_q, py_q, steps_q, drag_q;
  bit     landed_q;

  flight_rpt_t rpt_q[$];
  int  fail_cnt = 0;
  int  cyc_cnt = 0;
  int  idle_pct = 0;
  int  stall_pct = 0;
  int  hold_cycles = 0;

  function automatic longint clamp_v(longint v);
    if (v > VMAX) return VMAX;
    if (v < VMIN) return VMIN;
    return v;
  endfunction

  // Exact product, shifted with truncation toward zero, saturated
  function automatic longint mul_shift(longint a, longint b, int s);
    logic [63:0]  ua, ub;
    logic [127:0] p, lim;
    bit           neg;
    neg = (a < 0) != (b < 0);
    ua  = (a < 0) ? -a : a;
    ub  = (b < 0) ? -b : b;
    p   = {64'd0, ua} * {64'd0, ub};
    p   = p >> s;
    lim = neg ? 128'(VMAX) + 1 : 128'(VMAX);
    if (p > lim) p = lim;
    return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic longint drag_of(longint v);
    longint v2;
    v2 = mul_shift(v, (v < 0) ? -v : v, 16);
    return mul_shift(v2, drag_q, 32);
  endfunction

  function automatic flight_rpt_t flight_report();
    flight_rpt_t r;
    longint d;
    d = px_q - (target_q << 8);
    if (d < 0) d = -d;
    r.elapsed_steps = steps_q[15:0];
    r.range_x       = px_q[31:0];
    r.height_y      = py_q[31:0];
    r.landed        = landed_q;
    r.on_target     = landed_q && (d <= 65536);
    return r;
  endfunction

  // Advance the predicted flight by one accepted item
  task automatic predict_flight(bit op, logic [15:0] speed, logic [14:0] angle);
    longint z, cx, cy, dx, dy, m, ax, ay;
    bit flip;
    if (op == OP_LAUNCH) begin
      z = (longint'(angle) << 16) / 100;
      flip = 0;
      cx = CORDIC_K;
      cy = 0;
      if (z > DEG270) z -= DEG360;
      else if (z > DEG90) begin
        z -= DEG180;
        flip = 1;
      end
      for (int i = 0; i < 16; i++) begin
        dx = cy >>> i;
        dy = cx >>> i;
        if (z >= 0) begin
          cx -= dx; cy += dy; z -= atan_deg(i[3:0]);
        end else begin
          cx += dx; cy -= dy; z += atan_deg(i[3:0]);
        end
      end
      if (flip) begin
        cx = -cx; cy = -cy;
      end
      m = (mass_q == 0) ? 1 : mass_q;
      vx_q = clamp_v(mul_shift(speed, cx, 22) + wind_q * 256);
      vy_q = clamp_v(mul_shift(speed, cy, 22));
      px_q = 0; py_q = 0; steps_q = 0; landed_q = 0;
      drag_q = (rho_q * 64'd31708639) / (m << 16);
    end else if (!landed_q) begin
      ax = clamp_v(-drag_of(vx_q));
      ay = clamp_v(-longint'(G_Q16) - drag_of(vy_q));
      vx_q = clamp_v(vx_q + mul_shift(ax, DT_Q16, 16));
      vy_q = clamp_v(vy_q + mul_shift(ay, DT_Q16, 16));
      px_q = clamp_v(px_q + mul_shift(vx_q, DT_Q16, 16));
      py_q = clamp_v(py_q + mul_shift(vy_q, DT_Q16, 16));
      if (steps_q < 65535) steps_q++;
      if (py_q < 0) landed_q = 1;
    end
    rpt_q.push_back(flight_report());
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cyc_cnt, what, got, want);
    fail_cnt++;
  endtask

  // Send one item; valid stays high into the next call unless an idle gap follows
  task automatic send_item(bit op, logic [15:0] speed, logic [14:0] angle);
    if ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {1'b0, angle, speed};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_flight(op, speed, angle);
    @(negedge clk_i);
  endtask

  task automatic tick_item();
    send_item(OP_TICK, 16'($urandom), 15'($urandom));
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (rpt_q.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, longint value);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value[CfgDataW-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_AIR_DENSITY:  rho_q = value & 64'h3FFFF;
      REG_PROJ_MASS:    mass_q = value & 64'hFFFF;
      REG_WIND_SPEED:   wind_q = longint'($signed(value[14:0]));
      REG_TARGET_RANGE: target_q = value & 64'hFFFFFF;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_regs(longint rho, longint mass, longint wind, longint target);
    write_reg(REG_AIR_DENSITY, rho);
    write_reg(REG_PROJ_MASS, mass);
    write_reg(REG_WIND_SPEED, wind);
    write_reg(REG_TARGET_RANGE, target);
  endtask

  task automatic fly_until_landed(int max_ticks);
    for (int i = 0; i < max_ticks && !landed_q; i++) tick_item();
  endtask

  // Directed: extremes of speed and angle, tick before launch, frozen ticks, zero mass
  task automatic test_directed();
    longint hit_x;
    tick_item();
    tick_item();
    send_item(OP_LAUNCH, 16'd0, 15'd0);
    tick_item();
    send_item(OP_LAUNCH, 16'd65535, 15'd9000);
    tick_item();
    send_item(OP_LAUNCH, 16'd65535, 15'd18000);
    tick_item();
    send_item(OP_LAUNCH, 16'd65535, 15'd32767);
    tick_item();
    send_item(OP_LAUNCH, 16'd40000, 15'd27001);
    tick_item();
    set_regs(262143, 0, -16384, 16777215);
    send_item(OP_LAUNCH, 16'd65535, 15'd0);
    tick_item();
    tick_item();
    // Hit the target: fly once, aim the target at the landing point, fly again
    set_regs(80282, 100, 2560, 256000);
    send_item(OP_LAUNCH, 16'd5000, 15'd4500);
    fly_until_landed(200);
    hit_x = px_q >>> 8;
    write_reg(REG_TARGET_RANGE, (hit_x < 0) ? 0 : hit_x);
    send_item(OP_LAUNCH, 16'd5000, 15'd4500);
    fly_until_landed(200);
    tick_item();
  endtask

  // Random flights with occasional noise items
  task automatic test_random_flights(int n_items);
    int sent;
    logic [15:0] spd;
    logic [14:0] ang;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) begin
        send_item(1'($urandom), 16'($urandom), 15'($urandom));
        sent++;
      end else begin
        spd = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8000));
        ang = ($urandom_range(9) == 0) ? 15'($urandom) : 15'($urandom_range(0, 18000));
        send_item(OP_LAUNCH, spd, ang);
        sent++;
        for (int t = $urandom_range(1, 60); t > 0 && sent < n_items; t--) begin
          tick_item();
          sent++;
        end
      end
    end
  endtask

  // Receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    hold_cycles = 400;
    send_item(OP_LAUNCH, 16'd3000, 15'd6000);
    repeat (10) tick_item();
  endtask

  // Result stream ready with random stalls and long hold-offs
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    flight_rpt_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[81:0];
      if (rpt_q.size() == 0) begin
        report_mismatch("unexpected result, steps", got.elapsed_steps, -1);
      end else begin
        want = rpt_q.pop_front();
        if (got.elapsed_steps !== want.elapsed_steps)
          report_mismatch("elapsed_steps", got.elapsed_steps, want.elapsed_steps);
        if (got.range_x !== want.range_x)
          report_mismatch("range_x", $signed(got.range_x), $signed(want.range_x));
        if (got.height_y !== want.height_y)
          report_mismatch("height_y", $signed(got.height_y), $signed(want.height_y));
        if (got.landed !== want.landed)
          report_mismatch("landed", got.landed, want.landed);
        if (got.on_target !== want.on_target)
          report_mismatch("on_target", got.on_target, want.on_target);
      end
    end
  end

  // Timeout
  always @(posedge clk_i) begin
    cyc_cnt++;
    if (cyc_cnt > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rho_q = 80282; mass_q = 100; wind_q = 2560; target_q = 256000;
    vx_q = 0; vy_q = 0; px_q = 0; py_q = 0; steps_q = 0; drag_q = 0; landed_q = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    test_directed();
    set_regs(0, 1, 12800, 0);
    test_random_flights(200);
    idle_pct = 52;
    set_regs(131072, 65535, -12800, 16777215);
    test_random_flights(200);
    idle_pct = 0; stall_pct = 52;
    test_backpressure();
    set_regs(80282, 10, 0, 20000);
    test_random_flights(200);
    idle_pct = 27; stall_pct = 27;
    set_regs($urandom_range(0, 262143), $urandom_range(0, 65535),
             $urandom_range(0, 32767), $urandom_range(0, 16777215));
    test_random_flights(200);

    wait_idle();
    repeat (100) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/pds_pkg.sv
rtl/core/projectile_drag_stepper.sv
tb/tb_top.sv
